### hdl/bmh_pkg.sv
`timescale 1ns / 1ps

package bmh_pkg;

	localparam int HCW = 9;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] payload;
		logic signed [31:0] key;
	} entry_t;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] item_payload;
		logic signed [31:0] item_key;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_payload;
		logic signed [31:0] out_key;
		logic [1:0]         status;
		logic [HCW-1:0]     heap_count;
	} rsp_t;

endpackage

### hdl/bmh_ram.sv
`timescale 1ns / 1ps

module bmh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps

// Min-heap of (payload, key) pairs held in one RAM with a registered read port. A command is
// transferred when start is high and busy is low; its single result appears for exactly one
// cycle with done high and must be taken then, since the block cannot be held off. Full inserts
// and empty extracts answer in the cycle after the transfer. An insert reads the parent and
// compares once per level it rises; an extract first fetches the root and then the last entry,
// and per level it sinks reads the left child and then, if present, the right child. The heap
// RAM is read once per compare.
module binary_min_heap_priority_queue #(
	parameter int CAPACITY = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bmh_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output bmh_pkg::rsp_t rsp
);

	import bmh_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_UP_RD   = 8'b0000_0010,
		S_UP_CMP  = 8'b0000_0100,
		S_EX_ROOT = 8'b0000_1000,
		S_EX_LAST = 8'b0001_0000,
		S_DN_L    = 8'b0010_0000,
		S_DN_R    = 8'b0100_0000,
		S_DN_D    = 8'b1000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] idx_q, idx_d;
	entry_t        cur_q, cur_d;
	entry_t        best_q, best_d;
	logic          pick_left_q, pick_left_d;
	rsp_t          rsp_q, rsp_d;
	logic          done_q, done_d;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;

	logic [CW:0]   left_w, right_w, count_w;
	logic [AW-1:0] parent_w;
	logic          left_wins;

	bmh_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign left_w    = (CW + 1)'({idx_q, 1'b1});
	assign right_w   = left_w + 1'b1;
	assign count_w   = {1'b0, count_q};
	assign parent_w  = AW'((idx_q - 1'b1) >> 1);
	assign left_wins = $signed(ram_rdata.key) < $signed(cur_q.key);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		cur_d       = cur_q;
		best_d      = best_q;
		pick_left_d = pick_left_q;
		rsp_d       = rsp_q;
		done_d      = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = cur_q;
		ram_raddr   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.cmd == CMD_INSERT) begin
						rsp_d.out_payload = '0;
						rsp_d.out_key     = '0;
						if (count_q == CW'(CAPACITY)) begin
							rsp_d.status = ST_FULL;
							done_d       = 1'b1;
						end else begin
							rsp_d.status  = ST_OK;
							cur_d.payload = req.item_payload;
							cur_d.key     = req.item_key;
							idx_d         = count_q[AW-1:0];
							count_d       = count_q + 1'b1;
							state_d       = S_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							rsp_d.out_payload = '1;
							rsp_d.out_key     = '1;
							rsp_d.status      = ST_EMPTY;
							done_d            = 1'b1;
						end else begin
							ram_raddr = '0;
							count_d   = count_q - 1'b1;
							state_d   = S_EX_ROOT;
						end
					end
				end
			end
			S_UP_RD: begin
				if (idx_q == '0) begin
					ram_we  = 1'b1;
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					ram_raddr = parent_w;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if ($signed(cur_q.key) < $signed(ram_rdata.key)) begin
					ram_wdata = ram_rdata;
					idx_d     = parent_w;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_EX_ROOT: begin
				rsp_d.out_payload = ram_rdata.payload;
				rsp_d.out_key     = ram_rdata.key;
				rsp_d.status      = ST_OK;
				ram_raddr         = count_q[AW-1:0];
				state_d           = S_EX_LAST;
			end
			S_EX_LAST: begin
				cur_d = ram_rdata;
				idx_d = '0;
				if (count_q == '0) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				if (left_w >= count_w) begin
					ram_we  = 1'b1;
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					ram_raddr = left_w[AW-1:0];
					state_d   = S_DN_R;
				end
			end
			S_DN_R: begin
				best_d      = left_wins ? ram_rdata : cur_q;
				pick_left_d = left_wins;
				if (right_w < count_w) begin
					ram_raddr = right_w[AW-1:0];
					state_d   = S_DN_D;
				end else if (left_wins) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					idx_d     = left_w[AW-1:0];
					state_d   = S_DN_L;
				end else begin
					ram_we  = 1'b1;
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_DN_D: begin
				ram_we = 1'b1;
				if ($signed(ram_rdata.key) < $signed(best_q.key)) begin
					ram_wdata = ram_rdata;
					idx_d     = right_w[AW-1:0];
					state_d   = S_DN_L;
				end else if (pick_left_q) begin
					ram_wdata = best_q;
					idx_d     = left_w[AW-1:0];
					state_d   = S_DN_L;
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (done_d) begin
			rsp_d.heap_count = HCW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		cur_q       <= cur_d;
		best_q      <= best_d;
		pick_left_q <= pick_left_d;
		rsp_q       <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("A result was shown while a command was still in progress.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("The entry count exceeds the capacity.");

	a_start_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("A transferred command neither started work nor returned a result.");

	a_idx_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN_L || state_q == S_UP_RD) |-> CW'(idx_q) < count_q)
		else $error("The sift position lies outside the live entries.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> count_q == CW'(CAPACITY))
		else $error("An insert was dropped although the heap had room.");

endmodule

### tb/tb_binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps

module tb_binary_min_heap_priority_queue;

	import bmh_pkg::*;

	localparam int HEAP_DEPTH = 256;
	localparam int TOTAL_CMDS = 1250;
	localparam int DRAIN_CYCLES = 60;
	localparam int PEND_DEPTH = 64;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] NEG_ONE = -32'sd1;

	typedef struct {
		req_t cmd_req;
		bit   fixed;
		rsp_t fixed_rsp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	entry_t model_heap [HEAP_DEPTH];
	int unsigned model_len = 0;
	rsp_t pending_results [PEND_DEPTH];
	int unsigned pend_wr = 0;
	int unsigned pend_rd = 0;
	int mismatch_count = 0;
	int cmds_sent = 0;

	dir_row_t dir_tab [0:22] = '{
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b1, '{NEG_ONE, NEG_ONE, ST_EMPTY, 9'd0}},
		'{'{CMD_INSERT, KEY_MAX, KEY_MAX}, 1'b1, '{32'sd0, 32'sd0, ST_OK, 9'd1}},
		'{'{CMD_INSERT, KEY_MIN, KEY_MIN}, 1'b1, '{32'sd0, 32'sd0, ST_OK, 9'd2}},
		'{'{CMD_INSERT, 32'sd5, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, ST_OK, 9'd3}},
		'{'{CMD_INSERT, 32'sd6, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, ST_OK, 9'd4}},
		'{'{CMD_INSERT, NEG_ONE, NEG_ONE}, 1'b1, '{32'sd0, 32'sd0, ST_OK, 9'd5}},
		'{'{CMD_INSERT, 32'sd7, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b1, '{KEY_MIN, KEY_MIN, ST_OK, 9'd5}},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b1, '{NEG_ONE, NEG_ONE, ST_OK, 9'd4}},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b1, '{KEY_MAX, KEY_MAX, ST_OK, 9'd0}},
		'{'{CMD_EXTRACT, 32'sh1234, -32'sd5}, 1'b1, '{NEG_ONE, NEG_ONE, ST_EMPTY, 9'd0}},
		'{'{CMD_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa}, 1'b0, '0},
		'{'{CMD_INSERT, 32'shaaaa_aaaa, 32'sh5555_5555}, 1'b0, '0},
		'{'{CMD_INSERT, 32'sd0, KEY_MIN}, 1'b0, '0},
		'{'{CMD_INSERT, 32'sd1, KEY_MIN}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, 32'sd0, 32'sd0}, 1'b0, '0},
		'{'{CMD_EXTRACT, NEG_ONE, NEG_ONE}, 1'b0, '0}
	};

	binary_min_heap_priority_queue #(
		.CAPACITY(HEAP_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic rsp_t heap_apply(input req_t c);
		rsp_t r;
		int unsigned i;
		int unsigned up;
		int unsigned lc;
		int unsigned rc;
		int unsigned pick;
		entry_t t;
		r = '0;
		if (c.cmd == CMD_INSERT) begin
			if (model_len >= HEAP_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				model_heap[model_len] = '{c.item_payload, c.item_key};
				i = model_len;
				model_len++;
				while (i > 0) begin
					up = (i - 1) / 2;
					if (!($signed(model_heap[i].key) < $signed(model_heap[up].key)))
						break;
					t = model_heap[i];
					model_heap[i] = model_heap[up];
					model_heap[up] = t;
					i = up;
				end
			end
		end else if (model_len == 0) begin
			r.out_payload = NEG_ONE;
			r.out_key = NEG_ONE;
			r.status = ST_EMPTY;
		end else begin
			r.out_payload = model_heap[0].payload;
			r.out_key = model_heap[0].key;
			model_len--;
			model_heap[0] = model_heap[model_len];
			i = 0;
			while (1) begin
				lc = 2 * i + 1;
				rc = 2 * i + 2;
				pick = i;
				if (lc < model_len && $signed(model_heap[lc].key) < $signed(model_heap[pick].key))
					pick = lc;
				if (rc < model_len && $signed(model_heap[rc].key) < $signed(model_heap[pick].key))
					pick = rc;
				if (pick == i)
					break;
				t = model_heap[i];
				model_heap[i] = model_heap[pick];
				model_heap[pick] = t;
				i = pick;
			end
		end
		r.heap_count = model_len[HCW-1:0];
		return r;
	endfunction

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: return $signed($urandom_range(0, 15)) - 32'sd8;
			7: begin
				case ($urandom_range(0, 3))
					0: return KEY_MIN;
					1: return KEY_MAX;
					2: return 32'sd0;
					default: return NEG_ONE;
				endcase
			end
			default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
		endcase
	endfunction

	function automatic req_t rand_req(input int insert_pct);
		req_t c;
		c.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
		c.item_payload = $urandom;
		c.item_key = rand_key();
		return c;
	endfunction

	function automatic int idle_cycles(input bit allow_idle);
		int r;
		r = $urandom_range(0, 99);
		if (!allow_idle || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic push_command(input req_t c, input bit use_fixed, input rsp_t fixed_rsp,
			input int gap);
		rsp_t predicted;
		start <= 1'b1;
		req <= c;
		do @(posedge clk); while (busy);
		predicted = heap_apply(c);
		pending_results[pend_wr % PEND_DEPTH] = use_fixed ? fixed_rsp : predicted;
		pend_wr++;
		cmds_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pend_wr == pend_rd) begin
				$error("Result transfer with no command outstanding");
				mismatch_count++;
			end else begin
				want = pending_results[pend_rd % PEND_DEPTH];
				pend_rd++;
				cmp_field("out_payload", want.out_payload, rsp.out_payload);
				cmp_field("out_key", want.out_key, rsp.out_key);
				cmp_field("status", 32'(want.status), 32'(rsp.status));
				cmp_field("heap_count", 32'(want.heap_count), 32'(rsp.heap_count));
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[n])
			push_command(dir_tab[n].cmd_req, dir_tab[n].fixed, dir_tab[n].fixed_rsp,
				idle_cycles(1'b1));

		repeat (200)
			push_command(rand_req(50), 1'b0, '0, 0);

		while (model_len < HEAP_DEPTH)
			push_command(rand_req(90), 1'b0, '0, idle_cycles(1'b1));
		repeat (8)
			push_command(rand_req(100), 1'b0, '0, idle_cycles(1'b1));

		// Let the full heap settle completely before draining it.
		start <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);

		while (model_len > 0)
			push_command(rand_req(10), 1'b0, '0, idle_cycles(1'b1));
		repeat (5)
			push_command(rand_req(0), 1'b0, '0, idle_cycles(1'b1));

		while (cmds_sent < TOTAL_CMDS)
			push_command(rand_req(55), 1'b0, '0, idle_cycles(1'b1));

		start <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pend_wr == pend_rd) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
